### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands on i_clk, gated off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge out of reset
`define AST_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AST_HOLDS(lbl, expr, msg)
`define AST_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/core/pwm_icm_pkg.sv
// ----------------------------------------------------------------------------
// pwm_icm_pkg
// Shared widths, register indexes and unit status type of the capture core.
// ----------------------------------------------------------------------------
package pwm_icm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POLARITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_SPAN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK_HZ = 2'd3;

    localparam int SPAN_W = 17;
    localparam int CLK_W  = 28;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 17'd65535;
    localparam logic [CLK_W-1:0]  CLK_RESET  = 28'd72000000;

    // item fields
    localparam int CAP_W  = 16;
    localparam int TICK_W = 32;
    localparam int DUTY_W = 10;
    localparam int RAW_W  = 34;     // capture + overflows * span before masking

    // serial multiplier: A x B, B taken msb first
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // serial divider: one quotient bit per cycle
    localparam int DIV_N_W = MUL_P_W;
    localparam int DIV_D_W = TICK_W + 1;

    localparam int LEN_W = 6;       // holds lengths up to DIV_N_W

    localparam logic [MUL_B_W-1:0] US_PER_S  = 20'd1000000;
    localparam logic [DUTY_W-1:0]  PERMILLE  = 10'd1000;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

### rtl/core/pwm_input_capture_measure_core.sv
// ----------------------------------------------------------------------------
// pwm_input_capture_measure_core
// Turns timer capture edges into interval, high/low time, period, frequency,
// period in microseconds and duty in permille.
// ----------------------------------------------------------------------------
// One capture item is taken at a time. Its timestamp product, the duty and
// microsecond products, and the three quotients all run through one shared
// bit-serial multiplier and one shared restoring divider, one bit per cycle.
// The serial lengths (16 + 20 + 52 + 28 bits) plus the hand-offs between them
// set the time an item takes from acceptance to a valid result in simple
// mode; complex mode, once high plus low is nonzero, adds the 10-bit duty
// multiply and the 42-bit duty divide. The next item can be accepted in the
// cycle after the result is registered; a finished result that waits behind a
// stalled output holds off that acceptance. The result sits in an output
// register, so the next item is accepted while the previous one waits to be
// taken. Configuration writes must land while no item is in flight; writing
// start_polarity also reloads the edge polarity tracker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwm_input_capture_measure_core
    import pwm_icm_pkg::*;
#(
    parameter int STAMP_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CAP_W-1:0]      i_capture_value,
    input  logic [CAP_W-1:0]      i_overflow_count,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TICK_W-1:0]     o_interval_ticks,
    output logic [TICK_W-1:0]     o_high_ticks,
    output logic [TICK_W-1:0]     o_low_ticks,
    output logic [TICK_W-1:0]     o_period_ticks,
    output logic [CLK_W-1:0]      o_frequency_hz,
    output logic [TICK_W-1:0]     o_period_us,
    output logic [DUTY_W-1:0]     o_duty_permille,
    output logic                  o_ready_res,
    output logic                  o_edge_was_falling
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STAMP,
        S_UPDATE,
        S_PERIOD,
        S_DUTY_MUL,
        S_DUTY_DIV,
        S_US_MUL,
        S_US_DIV,
        S_FREQ_DIV,
        S_DONE
    } t_state;

    localparam int FREQ_PAD = DIV_N_W - CLK_W;
    localparam int DUTY_NUM = TICK_W + DUTY_W;
    localparam int DUTY_PAD = DIV_N_W - DUTY_NUM;
    localparam int OVF_PAD  = MUL_B_W - CAP_W;
    localparam int PRM_PAD  = MUL_B_W - DUTY_W;

    // configuration
    logic                   r_mode;
    logic [SPAN_W-1:0]      r_span;
    logic [CLK_W-1:0]       r_clk_hz;

    // measurement state
    logic [STAMP_WIDTH-1:0] r_last_stamp;
    logic [STAMP_WIDTH-1:0] r_stamp;
    logic [TICK_W-1:0]      r_high;
    logic [TICK_W-1:0]      r_low;
    logic                   r_pol;
    logic                   r_ready;

    // per-item working registers
    t_state                 r_state;
    logic [CAP_W-1:0]       r_cap;
    logic [CAP_W-1:0]       r_ovf;
    logic [TICK_W-1:0]      r_diff;
    logic [TICK_W:0]        r_sum;
    logic [TICK_W-1:0]      r_period;
    logic [DUTY_W-1:0]      r_duty;
    logic [TICK_W-1:0]      r_pus;
    logic [CLK_W-1:0]       r_freq;
    logic                   r_was_falling;
    logic                   r_mul_start;
    logic                   r_div_start;

    // output register
    logic                   r_out_valid;
    logic [TICK_W-1:0]      r_out_interval;
    logic [TICK_W-1:0]      r_out_high;
    logic [TICK_W-1:0]      r_out_low;
    logic [TICK_W-1:0]      r_out_period;
    logic [CLK_W-1:0]       r_out_freq;
    logic [TICK_W-1:0]      r_out_pus;
    logic [DUTY_W-1:0]      r_out_duty;
    logic                   r_out_ready;
    logic                   r_out_falling;

    // unit connections
    t_unit_sts              w_mul_sts;
    t_unit_sts              w_div_sts;
    logic [LEN_W-1:0]       w_mul_len;
    logic [MUL_A_W-1:0]     w_mul_a;
    logic [MUL_B_W-1:0]     w_mul_b;
    logic [MUL_P_W-1:0]     w_prod;
    logic [LEN_W-1:0]       w_div_len;
    logic [DIV_N_W-1:0]     w_div_num;
    logic [DIV_D_W-1:0]     w_div_den;
    logic [DIV_N_W-1:0]     w_quot;

    // datapath
    logic                   w_in_acc;
    logic                   w_out_free;
    logic [RAW_W-1:0]       w_raw;
    logic [63:0]            w_raw64;
    logic [STAMP_WIDTH-1:0] w_stamp_diff;
    logic [63:0]            w_diff64;
    logic [TICK_W-1:0]      w_diff;
    logic [TICK_W-1:0]      w_high_nx;
    logic [TICK_W-1:0]      w_low_nx;
    logic [TICK_W:0]        w_sum;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_raw   = RAW_W'(r_cap) + w_prod[RAW_W-1:0];
    assign w_raw64 = 64'(w_raw);

    assign w_stamp_diff = r_stamp - r_last_stamp;
    assign w_diff64     = 64'(w_stamp_diff);
    // wide stamps saturate the interval at 32 bits
    assign w_diff       = (w_diff64[63:TICK_W] != '0) ? '1 : w_diff64[TICK_W-1:0];

    assign w_high_nx = (r_mode && r_pol)  ? w_diff : r_high;
    assign w_low_nx  = (r_mode && !r_pol) ? w_diff : r_low;
    assign w_sum     = {1'b0, r_high} + {1'b0, r_low};

    // operands are picked by the state the unit starts in
    always_comb begin
        unique case (r_state)
            S_STAMP: begin
                w_mul_len = LEN_W'(CAP_W);
                w_mul_a   = MUL_A_W'(r_span);
                w_mul_b   = {r_ovf, {OVF_PAD{1'b0}}};
            end
            S_DUTY_MUL: begin
                w_mul_len = LEN_W'(DUTY_W);
                w_mul_a   = r_high;
                w_mul_b   = {PERMILLE, {PRM_PAD{1'b0}}};
            end
            default: begin
                w_mul_len = LEN_W'(MUL_B_W);
                w_mul_a   = r_period;
                w_mul_b   = US_PER_S;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_DUTY_DIV: begin
                w_div_len = LEN_W'(DUTY_NUM);
                w_div_num = {w_prod[DUTY_NUM-1:0], {DUTY_PAD{1'b0}}};
                w_div_den = r_sum;
            end
            S_US_DIV: begin
                w_div_len = LEN_W'(DIV_N_W);
                w_div_num = w_prod;
                w_div_den = DIV_D_W'(r_clk_hz);
            end
            default: begin
                w_div_len = LEN_W'(CLK_W);
                w_div_num = {r_clk_hz, {FREQ_PAD{1'b0}}};
                w_div_den = DIV_D_W'(r_period);
            end
        endcase
    end

    pwm_icm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_len   (w_mul_len),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_sts   (w_mul_sts),
        .o_prod  (w_prod)
    );

    pwm_icm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_len   (w_div_len),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_sts   (w_div_sts),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= 1'b0;
            r_span       <= SPAN_RESET;
            r_clk_hz     <= CLK_RESET;
            r_last_stamp <= '0;
            r_high       <= '0;
            r_low        <= '0;
            r_pol        <= 1'b0;
            r_ready      <= 1'b0;
            r_mul_start  <= 1'b0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MEASURE_MODE:   r_mode   <= i_cfg_data[0];
                    CFG_START_POLARITY: r_pol    <= i_cfg_data[0];
                    CFG_OVERFLOW_SPAN:  r_span   <= i_cfg_data[SPAN_W-1:0];
                    CFG_TIMER_CLOCK_HZ: r_clk_hz <= i_cfg_data[CLK_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cap       <= i_capture_value;
                        r_ovf       <= i_overflow_count;
                        r_mul_start <= 1'b1;
                        r_state     <= S_STAMP;
                    end
                end
                S_STAMP: begin
                    if (w_mul_sts.done) begin
                        r_stamp <= w_raw64[STAMP_WIDTH-1:0];
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_last_stamp  <= r_stamp;
                    r_diff        <= w_diff;
                    r_was_falling <= r_pol;
                    r_high        <= w_high_nx;
                    r_low         <= w_low_nx;
                    if (r_mode) begin
                        r_pol <= !r_pol;
                        if (w_high_nx != '0 && w_low_nx != '0) begin
                            r_ready <= 1'b1;
                        end
                    end else begin
                        r_ready <= 1'b1;
                    end
                    r_state <= S_PERIOD;
                end
                S_PERIOD: begin
                    r_sum       <= w_sum;
                    r_duty      <= '0;
                    r_mul_start <= 1'b1;
                    if (r_mode) begin
                        r_period <= w_sum[TICK_W] ? '1 : w_sum[TICK_W-1:0];
                    end else begin
                        r_period <= r_diff;
                    end
                    // duty only in complex mode with a nonzero period
                    r_state <= (r_mode && w_sum != '0) ? S_DUTY_MUL : S_US_MUL;
                end
                S_DUTY_MUL: begin
                    if (w_mul_sts.done) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DUTY_DIV;
                    end
                end
                S_DUTY_DIV: begin
                    if (w_div_sts.done) begin
                        r_duty      <= w_quot[DUTY_W-1:0];
                        r_mul_start <= 1'b1;
                        r_state     <= S_US_MUL;
                    end
                end
                S_US_MUL: begin
                    if (w_mul_sts.done) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_US_DIV;
                    end
                end
                S_US_DIV: begin
                    if (w_div_sts.done) begin
                        if (r_clk_hz == '0) begin
                            r_pus <= '0;
                        end else if (w_quot[DIV_N_W-1:TICK_W] != '0) begin
                            r_pus <= '1;
                        end else begin
                            r_pus <= w_quot[TICK_W-1:0];
                        end
                        r_div_start <= 1'b1;
                        r_state     <= S_FREQ_DIV;
                    end
                end
                S_FREQ_DIV: begin
                    if (w_div_sts.done) begin
                        r_freq  <= (r_period == '0) ? '0 : w_quot[CLK_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_interval <= r_diff;
            r_out_high     <= r_high;
            r_out_low      <= r_low;
            r_out_period   <= r_period;
            r_out_freq     <= r_freq;
            r_out_pus      <= r_pus;
            r_out_duty     <= r_duty;
            r_out_ready    <= r_ready;
            r_out_falling  <= r_was_falling;
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_interval_ticks   = r_out_interval;
    assign o_high_ticks       = r_out_high;
    assign o_low_ticks        = r_out_low;
    assign o_period_ticks     = r_out_period;
    assign o_frequency_hz     = r_out_freq;
    assign o_period_us        = r_out_pus;
    assign o_duty_permille    = r_out_duty;
    assign o_ready_res        = r_out_ready;
    assign o_edge_was_falling = r_out_falling;

    `AST_HOLDS(a_units_exclusive, !(w_mul_sts.busy && w_div_sts.busy), "mul and div both busy")
    `AST_NEXT(a_accept_starts_mul, w_in_acc, r_mul_start && r_state == S_STAMP, "no stamp mul")
    `AST_HOLDS(a_ready_sticky, !$fell(r_ready), "ready flag dropped")
    `AST_HOLDS(a_duty_range, !o_out_valid || o_duty_permille <= PERMILLE, "duty above 1000")
    `AST_HOLDS(a_freq_zero_period, !o_out_valid || |o_period_ticks || ~|o_frequency_hz, "freq")

endmodule

### rtl/core/pwm_icm_mul.sv
// ----------------------------------------------------------------------------
// pwm_icm_mul
// Bit-serial shift-and-add multiplier, multiplier operand taken msb first.
// ----------------------------------------------------------------------------
module pwm_icm_mul
    import pwm_icm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [LEN_W-1:0]   i_len,     // multiplier bits, left aligned in i_b
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output t_unit_sts          o_sts,
    output logic [MUL_P_W-1:0] o_prod
);

    logic               r_busy;
    logic               r_done;
    logic [LEN_W-1:0]   r_cnt;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_P_W-1:0] w_addend;

    assign w_addend = r_b[MUL_B_W-1] ? MUL_P_W'(r_a) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - LEN_W'(1);
                if (r_cnt == LEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[MUL_P_W-2:0], 1'b0} + w_addend;
            r_b   <= {r_b[MUL_B_W-2:0], 1'b0};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

### rtl/core/pwm_icm_div.sv
// ----------------------------------------------------------------------------
// pwm_icm_div
// Restoring divider, one quotient bit per cycle. The dividend arrives left
// aligned; after i_len steps the quotient sits in the low i_len bits.
// ----------------------------------------------------------------------------
module pwm_icm_div
    import pwm_icm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [LEN_W-1:0]   i_len,
    input  logic [DIV_N_W-1:0] i_num,
    input  logic [DIV_D_W-1:0] i_den,
    output t_unit_sts          o_sts,
    output logic [DIV_N_W-1:0] o_quot
);

    logic               r_busy;
    logic               r_done;
    logic [LEN_W-1:0]   r_cnt;
    logic [DIV_N_W-1:0] r_num;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_D_W-1:0] r_rem;

    logic [DIV_D_W:0]   w_part;
    logic [DIV_D_W+1:0] w_sub;
    logic               w_borrow;

    assign w_part   = {r_rem, r_num[DIV_N_W-1]};
    assign w_sub    = {1'b0, w_part} - {2'b00, r_den};
    assign w_borrow = w_sub[DIV_D_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - LEN_W'(1);
                if (r_cnt == LEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            // partial remainder stays below the divisor, so it fits DIV_D_W bits
            r_rem <= w_borrow ? w_part[DIV_D_W-1:0] : w_sub[DIV_D_W-1:0];
            r_num <= {r_num[DIV_N_W-2:0], ~w_borrow};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_num;

endmodule

### sim/pwm_input_capture_measure_core_tb.sv
// ----------------------------------------------------------------------------
// pwm_input_capture_measure_core_tb
// Drives capture items into the measurement core under random handshake
// pressure, predicts each result from a local copy of the timestamp, edge
// and configuration state, and compares every field of every result in order.
// ----------------------------------------------------------------------------
module pwm_input_capture_measure_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwm_icm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic [CAP_W-1:0] cap;
        logic [CAP_W-1:0] ovf;
    } t_capture;

    typedef struct {
        logic [TICK_W-1:0] interval;
        logic [TICK_W-1:0] high;
        logic [TICK_W-1:0] low;
        logic [TICK_W-1:0] period;
        logic [CLK_W-1:0]  freq;
        logic [TICK_W-1:0] period_us;
        logic [DUTY_W-1:0] duty;
        logic              ready;
        logic              falling;
    } t_measurement;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [CAP_W-1:0]      i_capture_value = '0;
    logic [CAP_W-1:0]      i_overflow_count = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [TICK_W-1:0]     o_interval_ticks;
    logic [TICK_W-1:0]     o_high_ticks;
    logic [TICK_W-1:0]     o_low_ticks;
    logic [TICK_W-1:0]     o_period_ticks;
    logic [CLK_W-1:0]      o_frequency_hz;
    logic [TICK_W-1:0]     o_period_us;
    logic [DUTY_W-1:0]     o_duty_permille;
    logic                  o_ready_res;
    logic                  o_edge_was_falling;

    pwm_input_capture_measure_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_capture_value    (i_capture_value),
        .i_overflow_count   (i_overflow_count),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_interval_ticks   (o_interval_ticks),
        .o_high_ticks       (o_high_ticks),
        .o_low_ticks        (o_low_ticks),
        .o_period_ticks     (o_period_ticks),
        .o_frequency_hz     (o_frequency_hz),
        .o_period_us        (o_period_us),
        .o_duty_permille    (o_duty_permille),
        .o_ready_res        (o_ready_res),
        .o_edge_was_falling (o_edge_was_falling)
    );

    // predictor copy of configuration and state
    logic              cfg_complex = 1'b0;
    logic [SPAN_W-1:0] cfg_span = SPAN_RESET;
    logic [CLK_W-1:0]  cfg_clk_hz = CLK_RESET;
    logic [TICK_W-1:0] prev_stamp = '0;
    logic [TICK_W-1:0] high_time = '0;
    logic [TICK_W-1:0] low_time = '0;
    logic              next_is_falling = 1'b0;
    logic              meas_ready = 1'b0;

    t_capture     pending_captures[$];
    t_measurement expected_measurements[$];
    t_capture     next_capture;
    t_measurement oldest_measurement;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_measurement measure_edge(input logic [CAP_W-1:0] cap,
                                                  input logic [CAP_W-1:0] ovf);
        t_measurement      m;
        longint unsigned   stamp;
        longint unsigned   sum;
        longint unsigned   period;
        longint unsigned   us;
        stamp = (64'(cap) + 64'(ovf) * 64'(cfg_span)) & 64'hffff_ffff;
        m.interval = 32'(stamp - 64'(prev_stamp));
        m.falling  = next_is_falling;
        m.duty     = '0;
        prev_stamp = stamp[TICK_W-1:0];
        if (!cfg_complex) begin
            meas_ready = 1'b1;
            period = 64'(m.interval);
        end else begin
            if (next_is_falling) begin
                high_time = m.interval;
                next_is_falling = 1'b0;
            end else begin
                low_time = m.interval;
                next_is_falling = 1'b1;
            end
            if (high_time != 0 && low_time != 0)
                meas_ready = 1'b1;
            // duty uses the full sum, period the saturated one
            sum = 64'(high_time) + 64'(low_time);
            period = (sum > 64'hffff_ffff) ? 64'hffff_ffff : sum;
            if (sum != 0)
                m.duty = DUTY_W'((64'(high_time) * 64'(PERMILLE)) / sum);
        end
        m.high   = high_time;
        m.low    = low_time;
        m.period = period[TICK_W-1:0];
        m.ready  = meas_ready;
        m.freq   = (period != 0) ? CLK_W'(64'(cfg_clk_hz) / period) : '0;
        if (cfg_clk_hz == 0) begin
            m.period_us = '0;
        end else begin
            us = (period * 64'(US_PER_S)) / 64'(cfg_clk_hz);
            m.period_us = (us > 64'hffff_ffff) ? 32'hffff_ffff : us[TICK_W-1:0];
        end
        return m;
    endfunction

    function automatic void compare_field(input string name, input longint unsigned got,
                                          input longint unsigned want);
        if (got != want) begin
            if (fail_count < 10)
                $display("mismatch %s: expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // input side: new item only once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid)
                expected_measurements.push_back(
                    measure_edge(i_capture_value, i_overflow_count));
            if (pending_captures.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_capture = pending_captures.pop_front();
                i_in_valid       <= 1'b1;
                i_capture_value  <= next_capture.cap;
                i_overflow_count <= next_capture.ovf;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_measurements.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: interval %0d", o_interval_ticks);
                    fail_count++;
                end else begin
                    oldest_measurement = expected_measurements.pop_front();
                    compare_field("interval_ticks", o_interval_ticks,
                                  oldest_measurement.interval);
                    compare_field("high_ticks", o_high_ticks, oldest_measurement.high);
                    compare_field("low_ticks", o_low_ticks, oldest_measurement.low);
                    compare_field("period_ticks", o_period_ticks, oldest_measurement.period);
                    compare_field("frequency_hz", o_frequency_hz, oldest_measurement.freq);
                    compare_field("period_us", o_period_us, oldest_measurement.period_us);
                    compare_field("duty_permille", o_duty_permille, oldest_measurement.duty);
                    compare_field("ready_res", o_ready_res, oldest_measurement.ready);
                    compare_field("edge_was_falling", o_edge_was_falling,
                                  oldest_measurement.falling);
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input int unsigned data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        case (idx)
            CFG_MEASURE_MODE: cfg_complex = data[0];
            CFG_START_POLARITY: next_is_falling = data[0];
            CFG_OVERFLOW_SPAN: cfg_span = data[SPAN_W-1:0];
            CFG_TIMER_CLOCK_HZ: cfg_clk_hz = data[CLK_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_capture(input logic [CAP_W-1:0] cap, input logic [CAP_W-1:0] ovf);
        t_capture c;
        c.cap = cap;
        c.ovf = ovf;
        pending_captures.push_back(c);
    endtask

    // checked at the falling edge so the driver's updates have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_captures.size() != 0 || i_in_valid || expected_measurements.size() != 0);
    endtask

    initial begin
        int          send_pcts[4];
        int          stall_pcts[4];
        logic [31:0] signal_pos;    // {overflows, count} of a running timer
        int          pick;
        send_pcts  = '{0, 81, 0, 24};
        stall_pcts = '{0, 0, 81, 24};
        signal_pos = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // complex mode from reset, first edge falling: ready only after both
        // high and low are nonzero; equal stamps give a zero interval
        write_reg(CFG_MEASURE_MODE, 1);
        write_reg(CFG_START_POLARITY, 1);
        queue_capture(16'd0, 16'd0);
        queue_capture(16'd100, 16'd0);
        queue_capture(16'd300, 16'd0);
        queue_capture(16'd300, 16'd0);
        queue_capture(16'hffff, 16'hffff);
        queue_capture(16'd0, 16'd0);
        queue_capture(16'd5, 16'd0);
        wait_idle();

        // back to simple mode with high/low carried over, then span extremes
        write_reg(CFG_MEASURE_MODE, 0);
        write_reg(CFG_OVERFLOW_SPAN, 0);
        queue_capture(16'd1234, 16'hffff);
        queue_capture(16'hffff, 16'd1);
        wait_idle();
        write_reg(CFG_OVERFLOW_SPAN, 'h1ffff);
        queue_capture(16'hffff, 16'hffff);
        queue_capture(16'd0, 16'd1);
        wait_idle();
        write_reg(CFG_TIMER_CLOCK_HZ, 0);
        queue_capture(16'd7, 16'd1);
        wait_idle();
        write_reg(CFG_TIMER_CLOCK_HZ, 'hfffffff);
        queue_capture(16'h5555, 16'haaaa);
        wait_idle();
        // slowest clock saturates the microsecond result
        write_reg(CFG_TIMER_CLOCK_HZ, 1);
        queue_capture(16'haaaa, 16'h5555);
        wait_idle();
        write_reg(CFG_OVERFLOW_SPAN, 1);
        write_reg(CFG_TIMER_CLOCK_HZ, 200000000);
        queue_capture(16'd0, 16'd0);
        queue_capture(16'd0, 16'd0);
        wait_idle();
        write_reg(CFG_MEASURE_MODE, 1);
        write_reg(CFG_START_POLARITY, 0);
        queue_capture(16'd10, 16'd0);
        queue_capture(16'd20, 16'd0);
        queue_capture(16'd20, 16'd0);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_MEASURE_MODE, $urandom_range(1));
            write_reg(CFG_START_POLARITY, $urandom_range(1));
            case ($urandom_range(5))
                0: write_reg(CFG_OVERFLOW_SPAN, 1);
                1: write_reg(CFG_OVERFLOW_SPAN, 65535);
                2: write_reg(CFG_OVERFLOW_SPAN, 65536);
                3: write_reg(CFG_OVERFLOW_SPAN, 0);
                4: write_reg(CFG_OVERFLOW_SPAN, 'h1ffff);
                default: write_reg(CFG_OVERFLOW_SPAN, $urandom_range(2, 65534));
            endcase
            case ($urandom_range(7))
                0: write_reg(CFG_TIMER_CLOCK_HZ, 1);
                1: write_reg(CFG_TIMER_CLOCK_HZ, 200000000);
                2: write_reg(CFG_TIMER_CLOCK_HZ, 72000000);
                3: write_reg(CFG_TIMER_CLOCK_HZ, 'hfffffff);
                4: write_reg(CFG_TIMER_CLOCK_HZ, 0);
                default: write_reg(CFG_TIMER_CLOCK_HZ, $urandom_range(1, 200000000));
            endcase
            send_idle_pct = send_pcts[ph % 4];
            stall_pct     = stall_pcts[ph % 4];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                // mostly a running timer with plausible pulse widths
                if (pick < 55)
                    signal_pos = signal_pos + $urandom_range(1, 3000);
                else if (pick < 70)
                    signal_pos = signal_pos + $urandom_range(3001, 400000);
                else if (pick < 85)
                    signal_pos = $urandom;
                else if (pick < 93)
                    signal_pos = signal_pos - $urandom_range(1, 5000);
                queue_capture(signal_pos[15:0], signal_pos[31:16]);
            end
            wait_idle();
        end

        send_idle_pct = 0;
        stall_pct = 0;
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_measurements.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
